/* hdl/dwc_pkg.sv */
// Package for the dosing weigher controller.
// Holds the opcode, phase and result-kind codes, the result record and shared helpers.
// No dependencies.
package dwc_pkg;

  typedef enum logic [2:0] {
    OP_FILL        = 3'd0,
    OP_CAL         = 3'd1,
    OP_STOP        = 3'd2,
    OP_SAMPLE      = 3'd3,
    OP_MOTOR_READY = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_TARE   = 3'd1,
    PH_WORK   = 3'd2,
    PH_RECONF = 3'd3,
    PH_MOTOR  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_UP       = 3'd0,
    KIND_DOWN     = 3'd1,
    KIND_STOP_ALL = 3'd2,
    KIND_WEIGH    = 3'd3,
    KIND_CAL      = 3'd4,
    KIND_MOTOR    = 3'd5
  } kind_t;

  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_MARGIN = 3'd1;
  localparam logic [2:0] REG_PCT    = 3'd2;
  localparam logic [2:0] REG_UP     = 3'd3;
  localparam logic [2:0] REG_DOWN   = 3'd4;

  // floor(x / 100) for x below 2**31 is (x * PCT_RECIP) >> PCT_SHIFT.
  localparam logic [31:0] PCT_RECIP = 32'd2748779070;
  localparam int          PCT_SHIFT = 38;
  localparam int          DELTA_W   = 25;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         power;
    logic signed [31:0] reading;
    logic               pass_flag;
    logic [15:0]        pass_count;
    logic [15:0]        fail_count;
    logic               last;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic result_t mk_result(input kind_t k, input logic [7:0] p,
                                        input logic signed [31:0] rd, input logic pf,
                                        input logic [15:0] pc, input logic [15:0] fc);
    result_t r;
    r.kind       = k;
    r.power      = p;
    r.reading    = rd;
    r.pass_flag  = pf;
    r.pass_count = pc;
    r.fail_count = fc;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

/* hdl/dwc_div.sv */
// Divider of an unsigned value by a small constant, done as a reciprocal multiply in chunks.
// Depends on nothing outside this file.
module dwc_div #(
  parameter int W = 35,
  parameter int D = 3
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  output logic         busy,
  output logic [W-1:0] quotient
);

  // With R = ceil(2**K / D), floor(x * R / 2**K) equals floor(x / D) for every x below 2**W.
  localparam int K     = W + $clog2(D) + 1;
  localparam int CHUNK = 10;
  localparam int STEPS = (K + CHUNK) / CHUNK;
  localparam int RPW   = STEPS * CHUNK;
  localparam int AW    = W + RPW;
  localparam int CW    = $clog2(STEPS + 1);
  localparam logic [RPW-1:0] RECIP = RPW'(((64'd1 << K) + 64'(D) - 64'd1) / 64'(D));

  logic [W-1:0]       x;
  logic [RPW-1:0]     rsh;
  logic [AW-1:0]      acc;
  logic [CW-1:0]      cnt;
  logic [W+CHUNK-1:0] part;

  assign part = (W+CHUNK)'(x) * (W+CHUNK)'(rsh[RPW-1 -: CHUNK]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= dividend;
      rsh <= RECIP;
      acc <= '0;
    end else if (cnt != '0) begin
      acc <= {acc[AW-CHUNK-1:0], {CHUNK{1'b0}}} + AW'(part);
      rsh <= {rsh[RPW-CHUNK-1:0], {CHUNK{1'b0}}};
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = acc[K +: W];

endmodule

/* hdl/dwc_fifo.sv */
// Dosing weigher result queue: takes up to two results a cycle, gives one unless stalled.
// Depends on dwc_pkg for the result record and the queue depth.
module dwc_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_n,
  input  dwc_pkg::result_t push0,
  input  dwc_pkg::result_t push1,
  output logic            space2,
  output logic            out_valid,
  input  logic            out_stall,
  output dwc_pkg::result_t head
);

  localparam int CNT_W = dwc_pkg::FIFO_AW + 1;

  dwc_pkg::result_t mem [dwc_pkg::FIFO_DEPTH];
  logic [dwc_pkg::FIFO_AW-1:0] wp;
  logic [dwc_pkg::FIFO_AW-1:0] rp;
  logic [CNT_W-1:0]            count;
  logic                        pop;

  assign pop       = out_valid & ~out_stall;
  assign out_valid = (count != '0);
  assign space2    = (count <= CNT_W'(dwc_pkg::FIFO_DEPTH - 2));
  assign head      = mem[rp];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wp] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wp + 1'b1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + dwc_pkg::FIFO_AW'(push_n);
      rp    <= rp + dwc_pkg::FIFO_AW'(pop);
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

endmodule

/* hdl/dosing_weigher_controller.sv */
// Top level of the dosing weigher controller: command decode, tare, fill control, registers.
// Depends on dwc_pkg, dwc_div (trimmed-mean divider) and dwc_fifo (result queue).
//
//   Channel    Direction  Handshake           Contents
//   input      in         in_valid/in_stall   opcode, sample, sample_valid
//   result     out        out_valid/out_stall kind, power, reading, pass_flag, counts, last
//   config     in         APB psel/penable    five setting registers at 4*i
//
// Results are queued at the same edge at which an item is taken, or, after a tare, when the mean is applied.
// The last tare sample starts the divider, a reciprocal multiply in four steps, and input
// stalls until the mean is applied.
// Input also stalls while fewer than two queue slots are free.
// Reset clears control state and the queue; stage thresholds are written by every fill tare, not by a calibration.
module dosing_weigher_controller #(
  parameter int TARE_SAMPLES = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] sample,
  input  logic               sample_valid,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         kind,
  output logic [7:0]         power,
  output logic signed [31:0] reading,
  output logic               pass_flag,
  output logic [15:0]        pass_count,
  output logic [15:0]        fail_count,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CNT_W   = $clog2(TARE_SAMPLES + 1);
  localparam int SUM_W   = 32 + $clog2(TARE_SAMPLES);
  localparam int DIVISOR = TARE_SAMPLES - 2;

  logic [23:0] target_counts;
  logic [23:0] margin_counts;
  logic [27:0] fill_percents;
  logic [23:0] up_powers;
  logic [23:0] down_powers;

  dwc_pkg::phase_t        phase, phase_next;
  logic                   calibrating, calibrating_next;
  logic [CNT_W-1:0]       tare_count, tare_count_next;
  logic signed [SUM_W-1:0] tare_sum, tare_sum_next;
  logic signed [31:0]     tare_min, tare_min_next;
  logic signed [31:0]     tare_max, tare_max_next;
  logic signed [31:0]     base_level, base_level_next;
  logic [31:0]            air_offset, air_offset_next;
  logic signed [31:0]     held_sample, held_sample_next;
  logic signed [31:0]     window_low, window_low_next;
  logic signed [31:0]     window_high, window_high_next;
  logic signed [31:0]     stage_threshold [4];
  logic signed [31:0]     stage_threshold_next [4];
  logic [3:0]             stage_done, stage_done_next;
  logic [15:0]            passed, passed_next;
  logic [15:0]            failed, failed_next;
  logic                   dividing, dividing_next;
  logic                   mean_neg, mean_neg_next;

  logic [30:0]                  pct_prod [4];
  logic [62:0]                  recip_prod [4];
  logic [dwc_pkg::DELTA_W-1:0]  pct_delta [4];

  logic             div_start;
  logic [SUM_W-1:0] div_dividend;
  logic             div_busy;
  logic [SUM_W-1:0] div_quotient;

  logic             space2;
  logic [1:0]       push_n;
  dwc_pkg::result_t res0, res1, push0, push1, head;
  logic             in_accept;
  logic             finish;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_counts <= '0;
      margin_counts <= '0;
      fill_percents <= '0;
      up_powers     <= '0;
      down_powers   <= '0;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        dwc_pkg::REG_TARGET: target_counts <= pwdata[23:0];
        dwc_pkg::REG_MARGIN: margin_counts <= pwdata[23:0];
        dwc_pkg::REG_PCT:    fill_percents <= pwdata[27:0];
        dwc_pkg::REG_UP:     up_powers     <= pwdata[23:0];
        dwc_pkg::REG_DOWN:   down_powers   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      dwc_pkg::REG_TARGET: prdata = {8'd0, target_counts};
      dwc_pkg::REG_MARGIN: prdata = {8'd0, margin_counts};
      dwc_pkg::REG_PCT:    prdata = {4'd0, fill_percents};
      dwc_pkg::REG_UP:     prdata = {8'd0, up_powers};
      dwc_pkg::REG_DOWN:   prdata = {8'd0, down_powers};
      default:             prdata = '0;
    endcase
  end

  // Stage offsets above base follow the settings through the registers pct_prod and pct_delta.
  for (genvar i = 0; i < 4; i++) begin : g_delta
    assign recip_prod[i] = {32'd0, pct_prod[i]} * {31'd0, dwc_pkg::PCT_RECIP};
    always_ff @(posedge clk) begin
      pct_prod[i]  <= {7'd0, target_counts} * {24'd0, fill_percents[7*i +: 7]};
      pct_delta[i] <= recip_prod[i][62:dwc_pkg::PCT_SHIFT];
    end
  end

  assign in_stall  = dividing | ~space2;
  assign in_accept = in_valid & ~in_stall;
  assign finish    = dividing & ~div_busy & space2;

  always_comb begin
    logic signed [SUM_W-1:0] sum_new;
    logic signed [SUM_W-1:0] trimmed;
    logic signed [31:0]      min_new;
    logic signed [31:0]      max_new;
    logic [CNT_W-1:0]        count_new;
    logic signed [31:0]      mean;
    logic signed [34:0]      b35;
    logic signed [33:0]      a34;
    logic signed [32:0]      d33;
    logic                    ok;

    phase_next       = phase;
    calibrating_next = calibrating;
    tare_count_next  = tare_count;
    tare_sum_next    = tare_sum;
    tare_min_next    = tare_min;
    tare_max_next    = tare_max;
    base_level_next  = base_level;
    air_offset_next  = air_offset;
    held_sample_next = held_sample;
    window_low_next  = window_low;
    window_high_next = window_high;
    for (int i = 0; i < 4; i++) begin
      stage_threshold_next[i] = stage_threshold[i];
    end
    stage_done_next = stage_done;
    passed_next     = passed;
    failed_next     = failed;
    dividing_next   = dividing;
    mean_neg_next   = mean_neg;
    div_start       = 1'b0;
    div_dividend    = '0;
    push_n          = 2'd0;
    res0 = dwc_pkg::mk_result(dwc_pkg::KIND_STOP_ALL, 8'd0, 32'sd0, 1'b0, 16'd0, 16'd0);
    res1 = res0;

    sum_new   = tare_sum + SUM_W'(sample);
    count_new = tare_count + 1'b1;
    min_new   = tare_min;
    max_new   = tare_max;
    if (tare_count == '0) begin
      min_new = sample;
      max_new = sample;
    end else if (tare_min > sample) begin
      min_new = sample;
    end else if (tare_max < sample) begin
      max_new = sample;
    end
    trimmed = sum_new - SUM_W'(min_new) - SUM_W'(max_new);

    mean = mean_neg ? -div_quotient[31:0] : div_quotient[31:0];
    b35  = 35'(mean);
    a34  = 34'(sample) + 34'(air_offset);
    d33  = 33'(sample) - 33'(held_sample);
    ok   = (sample <= window_high);

    if (finish) begin
      dividing_next = 1'b0;
      push_n        = 2'd2;
      if (calibrating) begin
        phase_next = dwc_pkg::PH_IDLE;
        res1 = dwc_pkg::mk_result(dwc_pkg::KIND_CAL, 8'd0, mean, 1'b0, 16'd0, 16'd0);
      end else begin
        base_level_next  = mean;
        window_low_next  = dwc_pkg::sat32(b35 + 35'(target_counts) - 35'(margin_counts));
        window_high_next = dwc_pkg::sat32(b35 + 35'(target_counts) + 35'(margin_counts));
        for (int i = 0; i < 4; i++) begin
          stage_threshold_next[i] = dwc_pkg::sat32(b35 + 35'(pct_delta[i]));
        end
        stage_done_next = 4'd0;
        phase_next      = dwc_pkg::PH_WORK;
        res0 = dwc_pkg::mk_result(dwc_pkg::KIND_UP, up_powers[7:0], 32'sd0, 1'b0,
                                  16'd0, 16'd0);
        res1 = dwc_pkg::mk_result(dwc_pkg::KIND_DOWN, down_powers[7:0], 32'sd0, 1'b0,
                                  16'd0, 16'd0);
      end
    end else if (in_accept) begin
      unique case (opcode)
        dwc_pkg::OP_FILL, dwc_pkg::OP_CAL: begin
          passed_next      = 16'd0;
          failed_next      = 16'd0;
          air_offset_next  = 32'd0;
          calibrating_next = (opcode == dwc_pkg::OP_CAL);
          stage_done_next  = 4'd0;
          phase_next       = dwc_pkg::PH_TARE;
          tare_count_next  = '0;
          tare_sum_next    = '0;
          tare_min_next    = 32'sd0;
          tare_max_next    = 32'sd0;
        end
        dwc_pkg::OP_STOP: begin
          phase_next      = dwc_pkg::PH_IDLE;
          tare_count_next = '0;
          tare_sum_next   = '0;
          push_n          = 2'd2;
          res0 = dwc_pkg::mk_result(dwc_pkg::KIND_MOTOR, 8'd0, 32'sd0, 1'b0, 16'd0, 16'd0);
        end
        dwc_pkg::OP_MOTOR_READY: begin
          if (phase == dwc_pkg::PH_MOTOR) begin
            push_n          = 2'd1;
            res0 = dwc_pkg::mk_result(dwc_pkg::KIND_MOTOR, 8'd0, 32'sd0, 1'b0, 16'd0, 16'd0);
            phase_next      = dwc_pkg::PH_TARE;
            tare_count_next = '0;
            tare_sum_next   = '0;
            tare_min_next   = 32'sd0;
            tare_max_next   = 32'sd0;
          end
        end
        dwc_pkg::OP_SAMPLE: begin
          if (sample_valid) begin
            unique case (phase)
              dwc_pkg::PH_TARE: begin
                tare_min_next = min_new;
                tare_max_next = max_new;
                if (count_new == CNT_W'(TARE_SAMPLES)) begin
                  tare_count_next = '0;
                  tare_sum_next   = '0;
                  div_start       = 1'b1;
                  div_dividend    = trimmed[SUM_W-1] ? -trimmed : trimmed;
                  mean_neg_next   = trimmed[SUM_W-1];
                  dividing_next   = 1'b1;
                end else begin
                  tare_count_next = count_new;
                  tare_sum_next   = sum_new;
                end
              end
              dwc_pkg::PH_WORK: begin
                if (a34 > 34'(window_low)) begin
                  held_sample_next = sample;
                  phase_next       = dwc_pkg::PH_RECONF;
                  push_n           = 2'd1;
                end else if (!stage_done[0] && a34 >= 34'(stage_threshold[0])) begin
                  stage_done_next[0] = 1'b1;
                  push_n = 2'd1;
                  res0 = dwc_pkg::mk_result(dwc_pkg::KIND_UP, up_powers[15:8], 32'sd0,
                                            1'b0, 16'd0, 16'd0);
                end else if (!stage_done[1] && a34 >= 34'(stage_threshold[1])) begin
                  stage_done_next[1] = 1'b1;
                  push_n = 2'd1;
                  res0 = dwc_pkg::mk_result(dwc_pkg::KIND_UP, up_powers[23:16], 32'sd0,
                                            1'b0, 16'd0, 16'd0);
                end else if (!stage_done[2] && a34 >= 34'(stage_threshold[2])) begin
                  stage_done_next[2] = 1'b1;
                  push_n = 2'd1;
                  res0 = dwc_pkg::mk_result(dwc_pkg::KIND_DOWN, down_powers[15:8], 32'sd0,
                                            1'b0, 16'd0, 16'd0);
                end else if (!stage_done[3] && a34 >= 34'(stage_threshold[3])) begin
                  stage_done_next[3] = 1'b1;
                  push_n = 2'd1;
                  res0 = dwc_pkg::mk_result(dwc_pkg::KIND_DOWN, down_powers[23:16], 32'sd0,
                                            1'b0, 16'd0, 16'd0);
                end
              end
              dwc_pkg::PH_RECONF: begin
                air_offset_next = d33[32] ? 32'(-d33) : d33[31:0];
                push_n          = 2'd2;
                if (sample < window_low) begin
                  phase_next = dwc_pkg::PH_WORK;
                  res0 = dwc_pkg::mk_result(dwc_pkg::KIND_UP, up_powers[23:16], 32'sd0,
                                            1'b0, 16'd0, 16'd0);
                  res1 = dwc_pkg::mk_result(dwc_pkg::KIND_DOWN, down_powers[23:16], 32'sd0,
                                            1'b0, 16'd0, 16'd0);
                end else begin
                  if (ok && passed != 16'hffff) begin
                    passed_next = passed + 1'b1;
                  end
                  if (!ok && failed != 16'hffff) begin
                    failed_next = failed + 1'b1;
                  end
                  phase_next = dwc_pkg::PH_MOTOR;
                  res0 = dwc_pkg::mk_result(dwc_pkg::KIND_WEIGH, 8'd0,
                                            dwc_pkg::sat32(35'(sample) - 35'(base_level)),
                                            ok, passed_next, failed_next);
                  res1 = dwc_pkg::mk_result(dwc_pkg::KIND_MOTOR, 8'd0, 32'sd0, 1'b1,
                                            16'd0, 16'd0);
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    push0 = res0;
    push1 = res1;
    push0.last = (push_n == 2'd1);
    push1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= dwc_pkg::PH_IDLE;
      calibrating <= 1'b0;
      tare_count  <= '0;
      tare_sum    <= '0;
      tare_min    <= 32'sd0;
      tare_max    <= 32'sd0;
      base_level  <= 32'sd0;
      air_offset  <= 32'd0;
      held_sample <= 32'sd0;
      window_low  <= 32'sd0;
      window_high <= 32'sd0;
      stage_done  <= 4'd0;
      passed      <= 16'd0;
      failed      <= 16'd0;
      dividing    <= 1'b0;
      mean_neg    <= 1'b0;
    end else begin
      phase       <= phase_next;
      calibrating <= calibrating_next;
      tare_count  <= tare_count_next;
      tare_sum    <= tare_sum_next;
      tare_min    <= tare_min_next;
      tare_max    <= tare_max_next;
      base_level  <= base_level_next;
      air_offset  <= air_offset_next;
      held_sample <= held_sample_next;
      window_low  <= window_low_next;
      window_high <= window_high_next;
      stage_done  <= stage_done_next;
      passed      <= passed_next;
      failed      <= failed_next;
      dividing    <= dividing_next;
      mean_neg    <= mean_neg_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      stage_threshold[i] <= stage_threshold_next[i];
    end
  end

  dwc_div #(
    .W(SUM_W),
    .D(DIVISOR)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  dwc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push0     (push0),
    .push1     (push1),
    .space2    (space2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign kind       = head.kind;
  assign power      = head.power;
  assign reading    = head.reading;
  assign pass_flag  = head.pass_flag;
  assign pass_count = head.pass_count;
  assign fail_count = head.fail_count;
  assign last       = head.last;

endmodule

/* hdl/dwc_checker.sv */
// Port-level checks for the dosing weigher controller, bound to the top level.
// Depends on dwc_pkg for the result kind codes.
module dwc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         kind,
  input logic [7:0]         power,
  input logic signed [31:0] reading,
  input logic               last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(reading))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_weigh_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == dwc_pkg::KIND_WEIGH |-> !last)
    else $error("weigh result not followed by motor start");

  a_power_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !(kind == dwc_pkg::KIND_UP || kind == dwc_pkg::KIND_DOWN) |-> power == 8'd0)
    else $error("power set on a non-feeder result");

endmodule

bind dosing_weigher_controller dwc_checker u_dwc_checker (.*);
